// File: rtl/ccs_pkg.sv
package ccs_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [4:0] {
    MODE_NORMAL     = 5'b00001,
    MODE_SLASH      = 5'b00010,
    MODE_LINE       = 5'b00100,
    MODE_BLOCK      = 5'b01000,
    MODE_BLOCK_STAR = 5'b10000
  } scan_mode_e;

  // One accepted item, reduced to the results it causes, in order:
  // held slash, the byte itself, end marker.
  typedef struct packed {
    logic       emit_slash;
    logic       emit_byte;
    logic       emit_end;
    logic       err;
    logic [7:0] data;
  } ccs_cmd_t;

endpackage

// File: rtl/ccs_front.sv
module ccs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              is_last_i,
  output logic              push_o,
  output ccs_pkg::ccs_cmd_t cmd_o,
  input  logic              full_i
);
  import ccs_pkg::*;

  scan_mode_e mode_q, mode_d;
  ccs_cmd_t   cmd;
  logic       accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    mode_d   = mode_q;
    cmd      = '0;
    cmd.data = in_byte_i;
    case (mode_q)
      MODE_SLASH: begin
        if (in_byte_i == ChSlash) begin
          mode_d = MODE_LINE;
        end else if (in_byte_i == ChStar) begin
          mode_d = MODE_BLOCK;
        end else begin
          cmd.emit_slash = 1'b1;
          mode_d         = MODE_NORMAL;
          cmd.emit_byte  = !(in_byte_i inside {ChLf, ChTab, ChVt, ChCr});
        end
      end
      MODE_LINE: begin
        if (in_byte_i == ChLf) begin
          mode_d = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (in_byte_i == ChStar) begin
          mode_d = MODE_BLOCK_STAR;
        end
      end
      MODE_BLOCK_STAR: begin
        if (in_byte_i == ChSlash) begin
          mode_d = MODE_NORMAL;
        end else if (in_byte_i != ChStar) begin
          mode_d = MODE_BLOCK;
        end
      end
      default: begin
        if (in_byte_i == ChSlash) begin
          mode_d = MODE_SLASH;
        end else begin
          mode_d        = MODE_NORMAL;
          cmd.emit_byte = !(in_byte_i inside {ChLf, ChTab, ChVt, ChCr});
        end
      end
    endcase
    if (is_last_i) begin
      if (mode_d == MODE_SLASH) begin
        cmd.emit_slash = 1'b1;
      end
      cmd.err      = (mode_d == MODE_BLOCK) || (mode_d == MODE_BLOCK_STAR);
      cmd.emit_end = 1'b1;
      mode_d       = MODE_NORMAL;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.emit_slash || cmd.emit_byte || cmd.emit_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

endmodule

// File: rtl/ccs_fifo.sv
module ccs_fifo #(
  parameter int unsigned Depth = ccs_pkg::FifoDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ccs_pkg::ccs_cmd_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ccs_pkg::ccs_cmd_t rdata_o
);
  import ccs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ccs_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/ccs_back.sv
module ccs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  ccs_pkg::ccs_cmd_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              end_of_text_o,
  output logic              open_comment_error_o
);
  import ccs_pkg::*;

  ccs_cmd_t   cur_q, cur_d, src, rest;
  logic       cur_busy;
  logic       have_src, load;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       byte_valid_q, byte_valid_d;
  logic       end_q, end_d;
  logic       err_q, err_d;

  assign cur_busy = cur_q.emit_slash || cur_q.emit_byte || cur_q.emit_end;
  assign src      = cur_busy ? cur_q : head_i;
  assign have_src = cur_busy || !empty_i;
  assign load     = !out_valid_q || out_ready_i;
  assign pop_o    = load && !cur_busy && !empty_i;

  always_comb begin
    rest         = src;
    out_byte_d   = '0;
    byte_valid_d = 1'b0;
    end_d        = 1'b0;
    err_d        = 1'b0;
    if (src.emit_slash) begin
      out_byte_d      = ChSlash;
      byte_valid_d    = 1'b1;
      rest.emit_slash = 1'b0;
    end else if (src.emit_byte) begin
      out_byte_d     = src.data;
      byte_valid_d   = 1'b1;
      rest.emit_byte = 1'b0;
    end else begin
      end_d         = 1'b1;
      err_d         = src.err;
      rest.emit_end = 1'b0;
    end
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = have_src;
      if (have_src) begin
        cur_d = rest;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cur_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && have_src) begin
      out_byte_q   <= out_byte_d;
      byte_valid_q <= byte_valid_d;
      end_q        <= end_d;
      err_q        <= err_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_byte_o           = out_byte_q;
  assign byte_valid_o         = byte_valid_q;
  assign end_of_text_o        = end_q;
  assign open_comment_error_o = err_q;

endmodule

// File: rtl/comment_and_control_stripper.sv
// Path: an accepted item is written into the command queue, and its first result is then
// loaded into the output register; each further result of that item follows in turn.
// Throughput: one item per cycle while each item causes at most one result and the sink
// keeps up; an item causing two or three results holds the single output register until
// each result is taken, and a small command queue absorbs the difference until it fills.
// Reset: asynchronous, active low; scanning restarts in normal text with an empty queue.
module comment_and_control_stripper #(
  parameter int unsigned FifoDepth = ccs_pkg::FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_text_o,
  output logic       open_comment_error_o
);
  import ccs_pkg::*;

  ccs_cmd_t push_cmd, head_cmd;
  logic     push, full, pop, empty;

  ccs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .is_last_i  (is_last_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  ccs_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head_cmd)
  );

  ccs_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .empty_i              (empty),
    .head_i               (head_cmd),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_byte_o           (out_byte_o),
    .byte_valid_o         (byte_valid_o),
    .end_of_text_o        (end_of_text_o),
    .open_comment_error_o (open_comment_error_o)
  );

endmodule

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       kept;
    logic       eot;
    logic       err;
  } stripped_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       pin;
    stripped_t  pinned;
  } text_row_t;

  localparam int unsigned ItemTarget = 350;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned LongHold   = 80;
  localparam stripped_t   NoPin      = '0;
  localparam stripped_t   EndOk      = {8'h00, 1'b0, 1'b1, 1'b0};
  localparam stripped_t   EndErr     = {8'h00, 1'b0, 1'b1, 1'b1};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       is_last_i   = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       end_of_text_o;
  logic       open_comment_error_o;

  scan_mode_e  strip_mode = MODE_NORMAL;
  stripped_t   stripped[$];
  logic [7:0]  text_buf[$];
  text_row_t   directed[22];
  int unsigned sent       = 0;
  int unsigned mismatches = 0;
  logic        hold_out   = 1'b0;

  comment_and_control_stripper u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .in_byte_i           (in_byte_i),
    .is_last_i           (is_last_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_byte_o          (out_byte_o),
    .byte_valid_o        (byte_valid_o),
    .end_of_text_o       (end_of_text_o),
    .open_comment_error_o(open_comment_error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void take_plain(input logic [7:0] b);
    if (b == ChSlash) begin
      strip_mode = MODE_SLASH;
    end else begin
      strip_mode = MODE_NORMAL;
      if (b != ChLf && b != ChTab && b != ChVt && b != ChCr) begin
        stripped.push_back({b, 1'b1, 1'b0, 1'b0});
      end
    end
  endfunction

  function automatic void strip_byte(input logic [7:0] b, input logic last,
                                     input logic pin, input stripped_t pinned);
    logic open_err;
    open_err = 1'b0;
    case (strip_mode)
      MODE_SLASH: begin
        if (b == ChSlash) begin
          strip_mode = MODE_LINE;
        end else if (b == ChStar) begin
          strip_mode = MODE_BLOCK;
        end else begin
          stripped.push_back({ChSlash, 1'b1, 1'b0, 1'b0});
          take_plain(b);
        end
      end
      MODE_LINE: begin
        if (b == ChLf) strip_mode = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (b == ChStar) strip_mode = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (b == ChSlash) begin
          strip_mode = MODE_NORMAL;
        end else if (b != ChStar) begin
          strip_mode = MODE_BLOCK;
        end
      end
      default: begin
        take_plain(b);
      end
    endcase
    if (last) begin
      if (strip_mode == MODE_SLASH) stripped.push_back({ChSlash, 1'b1, 1'b0, 1'b0});
      open_err = (strip_mode == MODE_BLOCK) || (strip_mode == MODE_BLOCK_STAR);
      stripped.push_back({8'h00, 1'b0, 1'b1, open_err});
      strip_mode = MODE_NORMAL;
    end
    if (pin) stripped[stripped.size() - 1] = pinned;
  endfunction

  function automatic logic [7:0] ctrl_char();
    case ($urandom_range(0, 3))
      0: return ChLf;
      1: return ChTab;
      2: return ChVt;
      default: return ChCr;
    endcase
  endfunction

  function automatic logic [7:0] text_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(8'h61, 8'h7A));
    if (r == 6) return ctrl_char();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic build_text();
    int unsigned tokens;
    int unsigned n;
    logic [7:0]  c;
    text_buf.delete();
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      case ($urandom_range(0, 5))
        0: begin
          n = $urandom_range(1, 4);
          repeat (n) text_buf.push_back(text_char());
        end
        1: begin
          text_buf.push_back(ChSlash);
          text_buf.push_back(ChSlash);
          n = $urandom_range(0, 5);
          repeat (n) begin
            c = text_char();
            if (c == ChLf) c = 8'h20;
            text_buf.push_back(c);
          end
          text_buf.push_back(ChLf);
        end
        2: begin
          text_buf.push_back(ChSlash);
          text_buf.push_back(ChStar);
          n = $urandom_range(0, 6);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0: c = ChStar;
              1: c = ChSlash;
              2: c = ChLf;
              default: c = text_char();
            endcase
            text_buf.push_back(c);
          end
          text_buf.push_back(ChStar);
          text_buf.push_back(ChSlash);
        end
        3: begin
          text_buf.push_back(ChSlash);
          c = text_char();
          if (c == ChSlash || c == ChStar) c = 8'h2B;
          text_buf.push_back(c);
        end
        4: begin
          text_buf.push_back(ctrl_char());
        end
        default: begin
          text_buf.push_back($urandom_range(0, 1) ? ChSlash : ChStar);
        end
      endcase
    end
    // Some texts are cut short so that comments are left open at the end.
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, text_buf.size());
      while (text_buf.size() > n) void'(text_buf.pop_back());
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic pin,
                           input stripped_t pinned, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    is_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    strip_byte(b, last, pin, pinned);
    sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (stripped.size() != 0);
  endtask

  task automatic send_text(input logic steady);
    for (int i = 0; i < text_buf.size(); i++) begin
      send_byte(text_buf[i], i == text_buf.size() - 1, 1'b0, NoPin,
                steady ? 0 : $urandom_range(0, 17));
    end
  endtask

  initial begin : stimulus
    logic steady;
    logic hold_done;
    logic drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    directed = '{
      {8'h41,   1'b0, 1'b1, {8'h41, 1'b1, 1'b0, 1'b0}},
      {8'h00,   1'b0, 1'b1, {8'h00, 1'b1, 1'b0, 1'b0}},
      {8'hFF,   1'b0, 1'b1, {8'hFF, 1'b1, 1'b0, 1'b0}},
      {ChLf,    1'b0, 1'b0, NoPin},
      {ChTab,   1'b0, 1'b0, NoPin},
      {ChVt,    1'b0, 1'b0, NoPin},
      {ChCr,    1'b0, 1'b0, NoPin},
      {ChSlash, 1'b0, 1'b0, NoPin},
      {8'h78,   1'b0, 1'b1, {8'h78, 1'b1, 1'b0, 1'b0}},
      {ChSlash, 1'b0, 1'b0, NoPin},
      {ChStar,  1'b0, 1'b0, NoPin},
      {ChSlash, 1'b0, 1'b0, NoPin},
      {ChStar,  1'b0, 1'b0, NoPin},
      {ChStar,  1'b0, 1'b0, NoPin},
      {ChSlash, 1'b0, 1'b0, NoPin},
      {ChSlash, 1'b0, 1'b0, NoPin},
      {ChSlash, 1'b0, 1'b0, NoPin},
      {8'h71,   1'b1, 1'b1, EndOk},
      {ChSlash, 1'b1, 1'b1, EndOk},
      {ChSlash, 1'b0, 1'b0, NoPin},
      {ChStar,  1'b0, 1'b0, NoPin},
      {ChStar,  1'b1, 1'b1, EndErr}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) begin
      send_byte(directed[i].data, directed[i].last, directed[i].pin, directed[i].pinned,
                ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0);
    end
    drain_results();
    while (sent < ItemTarget) begin
      steady = ($urandom_range(0, 2) == 0);
      if (!hold_done && sent > 150) begin
        // The sink stalls while a long run of plain bytes keeps the input busy.
        hold_done = 1'b1;
        hold_out  = 1'b1;
        text_buf.delete();
        repeat (40) text_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
        send_text(1'b1);
      end else if (!drain_done && sent > 250) begin
        drain_done = 1'b1;
        drain_results();
      end else if ($urandom_range(0, 6) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, NoPin,
                  steady ? 0 : $urandom_range(0, 17));
      end else begin
        build_text();
        send_text(steady);
      end
    end
    in_valid_i <= 1'b0;
    while (stripped.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : sink
    int unsigned pause;
    int unsigned taken;
    logic        steady;
    taken  = 0;
    steady = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) steady = $urandom_range(0, 1);
      pause = steady ? 0 : $urandom_range(0, 17);
      if (hold_out) begin
        pause    = LongHold;
        hold_out = 1'b0;
      end
      if (pause != 0) begin
        out_ready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      taken++;
    end
  end

  always @(posedge clk_i) begin : check_out
    stripped_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (stripped.size() == 0) begin
        $error("item with no expectation pending: out_byte %h end_of_text %b",
               out_byte_o, end_of_text_o);
        mismatches++;
      end else begin
        want = stripped.pop_front();
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_byte_o);
          mismatches++;
        end
        if (byte_valid_o !== want.kept) begin
          $error("byte_valid: expected %b, got %b", want.kept, byte_valid_o);
          mismatches++;
        end
        if (end_of_text_o !== want.eot) begin
          $error("end_of_text: expected %b, got %b", want.eot, end_of_text_o);
          mismatches++;
        end
        if (open_comment_error_o !== want.err) begin
          $error("open_comment_error: expected %b, got %b", want.err,
                 open_comment_error_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
